// ===== design/vertex_diffuse_lighting_defines.svh =====
// Assertion macros for the vertex diffuse lighting block.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef VERTEX_DIFFUSE_LIGHTING_DEFINES_SVH
`define VERTEX_DIFFUSE_LIGHTING_DEFINES_SVH

// Same-cycle implication.
`define VDL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VDL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vdl_pkg.sv =====
// Package for the vertex diffuse lighting block.
// Holds commands, register indexes, fixed widths and pipeline control type.
`timescale 1ns / 1ps

package vdl_pkg;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_LIGHT = 1'b1
  } vdl_cmd_e;

  typedef enum logic [1:0] {
    REG_LIGHT_COUNT   = 2'd0,
    REG_AMBIENT_RED   = 2'd1,
    REG_AMBIENT_GREEN = 2'd2,
    REG_AMBIENT_BLUE  = 2'd3
  } vdl_reg_e;

  localparam int unsigned FracBits = 14;
  localparam int unsigned CompW    = 16;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned ProdW    = 2 * CompW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned DotW     = 18;
  localparam int unsigned CProdW   = ColorW + DotW;
  localparam int unsigned AccW     = 30;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic use_l;
  } vdl_ctl_t;

endpackage

// ===== design/vertex_diffuse_lighting.sv =====
// Top level of the vertex diffuse lighting block.
// Depends on vdl_pkg and vertex_diffuse_lighting_defines.svh.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o): a load item (command 0) writes one
//   light table entry; a light item (command 1) shades one vertex normal.
//   Output channel (out_valid_o/out_ready_i): one RGB item per light item.
//   Config port: cfg_we_i writes register cfg_index_i with cfg_wdata_i.
//   Timing: a light item is issued to the lighting pipeline one table entry
//   per cycle unless the output stalls, max(min(light_count,MAX_LIGHTS),1)
//   entries in all, and the input is not ready until the last entry issues.
//   A load item is written into the light table when it is accepted. The
//   light loop runs through five register stages: table read, direction
//   products, dot, color products, accumulate.
//   Reset clears control, counters and configuration registers; the light
//   table holds nothing defined until loaded.
//   When the receiver stalls, the whole pipeline holds and no item is lost.
`timescale 1ns / 1ps

`include "vertex_diffuse_lighting_defines.svh"

module vertex_diffuse_lighting #(
  parameter int unsigned MAX_LIGHTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [2:0]  light_index_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic [7:0]  light_red_i,
  input  logic [7:0]  light_green_i,
  input  logic [7:0]  light_blue_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_wdata_i
);

  localparam int unsigned IW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned CW = $clog2(MAX_LIGHTS + 1);
  localparam int unsigned FB = vdl_pkg::FracBits;
  localparam int unsigned CPW = vdl_pkg::CompW;
  localparam int unsigned COW = vdl_pkg::ColorW;
  localparam int unsigned PW = vdl_pkg::ProdW;
  localparam int unsigned SW = vdl_pkg::SumW;
  localparam int unsigned DW = vdl_pkg::DotW;
  localparam int unsigned XW = vdl_pkg::CProdW;
  localparam int unsigned AW = vdl_pkg::AccW;

  // Light table and configuration.
  logic signed [CPW-1:0] tab_dir_q [MAX_LIGHTS][3];
  logic [COW-1:0]        tab_rgb_q [MAX_LIGHTS][3];
  logic [3:0]            light_count_q;
  logic [COW-1:0]        ambient_q [3];

  // Issue control.
  logic                  busy_q;
  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         active_q;
  logic [CW-1:0]         active_d;
  logic signed [CPW-1:0] nrm_q [3];

  logic en;
  logic in_acc;
  logic load_acc;
  logic vert_acc;
  logic issue_last;
  logic [IW-1:0] rd_idx;

  vdl_pkg::vdl_ctl_t ctl_d, s1_q, s2_q, s3_q, s4_q;

  logic signed [CPW-1:0] s1_dir_q [3];
  logic signed [CPW-1:0] s1_nrm_q [3];
  logic [COW-1:0]        s1_rgb_q [3];
  logic signed [PW-1:0]  s2_prod_q [3];
  logic [COW-1:0]        s2_rgb_q [3];
  logic signed [SW-1:0]  s3_sum;
  logic [DW-1:0]         s3_dot_q;
  logic [COW-1:0]        s3_rgb_q [3];
  logic [XW-1:0]         s4_prod_q [3];
  logic [AW-1:0]         acc_q [3];
  logic [AW-1:0]         acc_d [3];
  logic [COW-1:0]        sat_d [3];
  logic                  out_valid_q;
  logic [COW-1:0]        out_q [3];

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en && !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && (command_i == vdl_pkg::CMD_LOAD);
  assign vert_acc   = in_acc && (command_i == vdl_pkg::CMD_LIGHT);

  always_comb begin
    if ({28'd0, light_count_q} > MAX_LIGHTS) begin
      active_d = CW'(MAX_LIGHTS);
    end else begin
      active_d = CW'(light_count_q);
    end
  end

  assign issue_last = ({1'b0, cnt_q} + (CW+1)'(1)) >= {1'b0, active_q};
  assign rd_idx     = cnt_q[IW-1:0];

  always_comb begin
    ctl_d.vld   = busy_q;
    ctl_d.first = (cnt_q == '0);
    ctl_d.last  = issue_last;
    ctl_d.use_l = (active_q != '0);
  end

  // Configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_count_q <= '0;
      for (int c = 0; c < 3; c++) ambient_q[c] <= '0;
    end else if (cfg_we_i) begin
      case (vdl_pkg::vdl_reg_e'(cfg_index_i))
        vdl_pkg::REG_LIGHT_COUNT:   light_count_q <= cfg_wdata_i[3:0];
        vdl_pkg::REG_AMBIENT_RED:   ambient_q[0]  <= cfg_wdata_i;
        vdl_pkg::REG_AMBIENT_GREEN: ambient_q[1]  <= cfg_wdata_i;
        vdl_pkg::REG_AMBIENT_BLUE:  ambient_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Light table writes.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_LIGHTS; i++) begin
      if (load_acc && ({29'd0, light_index_i} == i)) begin
        tab_dir_q[i][0] <= dir_x_i;
        tab_dir_q[i][1] <= dir_y_i;
        tab_dir_q[i][2] <= dir_z_i;
        tab_rgb_q[i][0] <= light_red_i;
        tab_rgb_q[i][1] <= light_green_i;
        tab_rgb_q[i][2] <= light_blue_i;
      end
    end
  end

  // Issue one table entry per cycle while the output does not stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      active_q <= '0;
    end else if (en) begin
      if (vert_acc) begin
        busy_q   <= 1'b1;
        cnt_q    <= '0;
        active_q <= active_d;
      end else if (busy_q) begin
        if (issue_last) begin
          busy_q <= 1'b0;
        end
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vert_acc) begin
      nrm_q[0] <= normal_x_i;
      nrm_q[1] <= normal_y_i;
      nrm_q[2] <= normal_z_i;
    end
  end

  // Pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (en) begin
      s1_q <= ctl_d;
      s2_q <= s1_q;
      s3_q <= s2_q;
      s4_q <= s3_q;
    end
  end

  assign s3_sum = SW'(s2_prod_q[0]) + SW'(s2_prod_q[1]) + SW'(s2_prod_q[2]);

  // Pipeline data.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        s1_dir_q[c]  <= tab_dir_q[rd_idx][c];
        s1_rgb_q[c]  <= tab_rgb_q[rd_idx][c];
        s1_nrm_q[c]  <= nrm_q[c];
        s2_prod_q[c] <= s1_dir_q[c] * s1_nrm_q[c];
        s2_rgb_q[c]  <= s1_rgb_q[c];
        s3_rgb_q[c]  <= s2_q.use_l ? s2_rgb_q[c] : '0;
        s4_prod_q[c] <= XW'(s3_rgb_q[c]) * XW'(s3_dot_q);
      end
      if (s2_q.use_l && (s3_sum >= SW'(1 << FB))) begin
        s3_dot_q <= s3_sum[FB+DW-1:FB];
      end else begin
        s3_dot_q <= '0;
      end
    end
  end

  // Accumulate and saturate.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s4_q.first) begin
        acc_d[c] = (AW'(ambient_q[c]) << FB) + AW'(s4_prod_q[c]);
      end else begin
        acc_d[c] = acc_q[c] + AW'(s4_prod_q[c]);
      end
      if (acc_d[c][AW-1:FB] > (AW-FB)'(255)) begin
        sat_d[c] = '1;
      end else begin
        sat_d[c] = acc_d[c][FB+COW-1:FB];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s4_q.vld) begin
      for (int c = 0; c < 3; c++) acc_q[c] <= acc_d[c];
    end
    if (en && s4_q.vld && s4_q.last) begin
      for (int c = 0; c < 3; c++) out_q[c] <= sat_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s4_q.vld && s4_q.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_q[0];
  assign green_o     = out_q[1];
  assign blue_o      = out_q[2];

  `VDL_ASSERT_NEXT(a_vertex_starts_issue, vert_acc, busy_q && (cnt_q == '0),
    "light item did not start issuing")
  `VDL_ASSERT_NOW(a_cnt_in_range, busy_q && (active_q != '0), cnt_q < active_q,
    "issue counter beyond active lights")
  `VDL_ASSERT_NEXT(a_issue_enters_pipe, busy_q && en, s1_q.vld,
    "issued entry missing from pipeline")

endmodule

// ===== test/vertex_diffuse_lighting_checker.sv =====
// Checker for the vertex diffuse lighting block: watches the input, output and
// register write ports, predicts each lit color and compares. Depends on vdl_pkg.
`timescale 1ns / 1ps

module vertex_diffuse_lighting_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               command_i,
  input  logic [2:0]         light_index_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  input  logic [7:0]         light_red_i,
  input  logic [7:0]         light_green_i,
  input  logic [7:0]         light_blue_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [7:0]         cfg_wdata_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lit_color_t;

  logic signed [15:0] dir_tab [8][3];
  logic [7:0]         rgb_tab [8][3];
  logic [3:0]         light_count;
  logic [7:0]         ambient [3];
  lit_color_t         lit_colors_q[$];
  int                 fail_count = 0;

  assign pending_o    = lit_colors_q.size();
  assign fail_count_o = fail_count;

  function automatic lit_color_t shade(logic signed [15:0] nx, logic signed [15:0] ny,
                                       logic signed [15:0] nz);
    longint     acc [3];
    longint     s;
    longint     dot;
    int         active;
    lit_color_t res;
    logic [7:0] ch [3];
    active = (light_count > 8) ? 8 : light_count;
    for (int c = 0; c < 3; c++) acc[c] = longint'(ambient[c]) << 14;
    for (int l = 0; l < active; l++) begin
      s = longint'(dir_tab[l][0]) * nx + longint'(dir_tab[l][1]) * ny +
          longint'(dir_tab[l][2]) * nz;
      if (s >= 16384) begin
        dot = s >>> 14;
        for (int c = 0; c < 3; c++) acc[c] += longint'(rgb_tab[l][c]) * dot;
      end
    end
    for (int c = 0; c < 3; c++) ch[c] = ((acc[c] >> 14) > 255) ? 8'd255 : 8'(acc[c] >> 14);
    res.red = ch[0];
    res.green = ch[1];
    res.blue = ch[2];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lit_color_t exp_c;
    if (!rst_ni) begin
      light_count = '0;
      for (int c = 0; c < 3; c++) ambient[c] = '0;
      lit_colors_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (vdl_pkg::vdl_reg_e'(cfg_index_i))
          vdl_pkg::REG_LIGHT_COUNT:   light_count = cfg_wdata_i[3:0];
          vdl_pkg::REG_AMBIENT_RED:   ambient[0] = cfg_wdata_i;
          vdl_pkg::REG_AMBIENT_GREEN: ambient[1] = cfg_wdata_i;
          vdl_pkg::REG_AMBIENT_BLUE:  ambient[2] = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (lit_colors_q.size() == 0) begin
          $display("%0t: unexpected item r=%0d g=%0d b=%0d", $time, red_i, green_i, blue_i);
          fail_count++;
        end else begin
          exp_c = lit_colors_q.pop_front();
          if (exp_c.red !== red_i || exp_c.green !== green_i || exp_c.blue !== blue_i) begin
            $display("%0t: expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d", $time,
                     exp_c.red, exp_c.green, exp_c.blue, red_i, green_i, blue_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (vdl_pkg::vdl_cmd_e'(command_i) == vdl_pkg::CMD_LOAD) begin
          dir_tab[light_index_i][0] = dir_x_i;
          dir_tab[light_index_i][1] = dir_y_i;
          dir_tab[light_index_i][2] = dir_z_i;
          rgb_tab[light_index_i][0] = light_red_i;
          rgb_tab[light_index_i][1] = light_green_i;
          rgb_tab[light_index_i][2] = light_blue_i;
        end else begin
          lit_colors_q.push_back(shade(normal_x_i, normal_y_i, normal_z_i));
        end
      end
    end
  end

endmodule

// ===== test/vertex_diffuse_lighting_tb.sv =====
// Testbench top for the vertex diffuse lighting block: drives loads, lit
// vertices and register writes. Depends on vdl_pkg and the checker module.
`timescale 1ns / 1ps

module vertex_diffuse_lighting_tb;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               command = 1'b0;
  logic [2:0]         light_index = '0;
  logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic [7:0]         light_red = '0, light_green = '0, light_blue = '0;
  logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [7:0]         red, green, blue;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [7:0]         cfg_wdata = '0;
  int                 pending;
  int                 fail_count;
  bit                 calm = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  vertex_diffuse_lighting i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .command_i(command), .light_index_i(light_index),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .light_red_i(light_red), .light_green_i(light_green), .light_blue_i(light_blue),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .normal_z_i(normal_z),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .red_o(red), .green_o(green), .blue_o(blue),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata)
  );

  vertex_diffuse_lighting_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .command_i(command), .light_index_i(light_index),
    .dir_x_i(dir_x), .dir_y_i(dir_y), .dir_z_i(dir_z),
    .light_red_i(light_red), .light_green_i(light_green), .light_blue_i(light_blue),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .normal_z_i(normal_z),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .red_i(red), .green_i(green), .blue_i(blue),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_wdata_i(cfg_wdata),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(negedge clk_i) out_ready <= calm || ($urandom_range(99) >= 19);

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  // Valid stays high across back-to-back items; drop it only to idle.
  task automatic push_item(vdl_pkg::vdl_cmd_e cmd, logic [2:0] idx,
                           logic signed [15:0] a, logic signed [15:0] b,
                           logic signed [15:0] c, logic [7:0] r, logic [7:0] g,
                           logic [7:0] bl);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    command = cmd;
    light_index = idx;
    light_red = r;
    light_green = g;
    light_blue = bl;
    if (cmd == vdl_pkg::CMD_LOAD) begin
      dir_x = a; dir_y = b; dir_z = c;
      normal_x = 16'($urandom); normal_y = 16'($urandom); normal_z = 16'($urandom);
    end else begin
      normal_x = a; normal_y = b; normal_z = c;
      dir_x = 16'($urandom); dir_y = 16'($urandom); dir_z = 16'($urandom);
    end
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  task automatic load_light(logic [2:0] idx, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b);
    push_item(vdl_pkg::CMD_LOAD, idx, x, y, z, r, g, b);
  endtask

  task automatic light_vertex(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
    push_item(vdl_pkg::CMD_LIGHT, 3'($urandom), x, y, z, 8'($urandom), 8'($urandom),
              8'($urandom));
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(vdl_pkg::vdl_reg_e idx, logic [7:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_lighting(logic [7:0] count, logic [7:0] r, logic [7:0] g,
                              logic [7:0] b);
    drain();
    write_reg(vdl_pkg::REG_LIGHT_COUNT, count);
    write_reg(vdl_pkg::REG_AMBIENT_RED, r);
    write_reg(vdl_pkg::REG_AMBIENT_GREEN, g);
    write_reg(vdl_pkg::REG_AMBIENT_BLUE, b);
  endtask

  initial begin
    #20_000_000;
    $display("vertex_diffuse_lighting: mismatch");
    $finish;
  end

  initial begin
    int count_sel;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    light_vertex(16'sd16384, 16'sd16384, 16'sd16384);
    load_light(3'd0, 16'sd16384, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255);
    load_light(3'd1, -16'sd16384, 16'sd0, 16'sd0, 8'd255, 8'd0, 8'd128);
    load_light(3'd2, 16'sd0, 16'sd16384, 16'sd0, 8'd0, 8'd255, 8'd0);
    load_light(3'd3, 16'sd0, 16'sd0, -16'sd16384, 8'd0, 8'd0, 8'd255);
    load_light(3'd4, 16'sd16384, 16'sd16384, 16'sd16384, 8'd1, 8'd2, 8'd3);
    load_light(3'd5, 16'sh7fff, 16'sh7fff, 16'sh7fff, 8'd255, 8'd255, 8'd255);
    load_light(3'd6, -16'sd32768, 16'sd0, 16'sd0, 8'd255, 8'd255, 8'd255);
    load_light(3'd7, 16'sd1, 16'sd1, 16'sd1, 8'd77, 8'd88, 8'd99);
    set_lighting(8'd8, 8'd0, 8'd0, 8'd0);
    light_vertex(16'sd16384, 16'sd0, 16'sd0);
    light_vertex(-16'sd16384, 16'sd0, 16'sd0);
    light_vertex(16'sd0, 16'sd0, 16'sd0);
    light_vertex(16'sd0, 16'sd16384, 16'sd16384);
    light_vertex(16'sd1, 16'sd0, 16'sd0);
    light_vertex(-16'sd32768, -16'sd32768, -16'sd32768);
    light_vertex(16'sh7fff, 16'sh7fff, 16'sh7fff);
    set_lighting(8'd15, 8'd255, 8'd255, 8'd255);
    light_vertex(16'sd0, 16'sd0, 16'sd0);
    light_vertex(16'sd16384, -16'sd16384, 16'sd16384);
    set_lighting(8'd1, 8'd10, 8'd200, 8'd0);
    light_vertex(16'sd16384, 16'sd0, 16'sd0);
    light_vertex(16'sd8192, 16'sd0, 16'sd0);
    set_lighting(8'd0, 8'd0, 8'd0, 8'd0);
    light_vertex(16'sd16384, 16'sd0, 16'sd0);

    for (int phase = 0; phase < 8; phase++) begin
      count_sel = $urandom_range(9);
      calm = (phase == 3);
      case (count_sel)
        0: set_lighting(8'd0, 8'($urandom), 8'($urandom), 8'($urandom));
        1: set_lighting(8'd8, 8'd255, 8'd255, 8'd255);
        2: set_lighting(8'($urandom_range(15, 9)) | 8'($urandom) & 8'hf0, 8'd0, 8'd0, 8'd0);
        default: set_lighting(8'($urandom_range(8)), 8'($urandom_range(64)),
                              8'($urandom_range(64)), 8'($urandom_range(64)));
      endcase
      repeat (200) begin
        if ($urandom_range(99) < 30)
          load_light(3'($urandom), rand_comp(), rand_comp(), rand_comp(),
                     8'($urandom), 8'($urandom), 8'($urandom));
        else
          light_vertex(rand_comp(), rand_comp(), rand_comp());
      end
    end
    calm = 1'b0;
    drain();

    if (fail_count == 0) begin
      $display("vertex_diffuse_lighting: match");
    end else begin
      $display("vertex_diffuse_lighting: mismatch");
    end
    $finish;
  end

endmodule
